>>> rtl/cwts_pkg.sv
package cwts_pkg;

  // Field widths.
  localparam int unsigned PosW    = 20;
  localparam int unsigned DiffW   = 21;
  localparam int unsigned ChargeW = 24;
  localparam int unsigned AxisW   = 18;
  localparam int unsigned SepW    = 21;
  localparam int unsigned TotW    = 40;
  localparam int unsigned SumW    = 64;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_VERTEX_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VERTEX_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VERTEX_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_START_X  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_START_Y  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_START_Z  = 3'd5;

  // Operation codes of the shared root/divide unit.
  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } rd_op_e;

  localparam logic [SepW-1:0] SEP_MAX = 21'h1FFFFF;

endpackage

>>> rtl/cwts_mul.sv
module cwts_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;

  // One signed 32 by 32 product, registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/cwts_rootdiv.sv
module cwts_rootdiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  cwts_pkg::rd_op_e    op_i,
  input  logic [63:0]         num_i,
  input  logic [63:0]         den_i,
  output logic                done_o,
  output logic [63:0]         res_o
);

  logic [65:0]      rem_q, rem_d;
  logic [63:0]      wrk_q, wrk_d;
  logic [63:0]      res_q, res_d;
  logic [63:0]      den_q, den_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  cwts_pkg::rd_op_e op_q, op_d;

  logic [65:0] rem_sh;
  logic [65:0] trial;
  logic        fits;

  // One restoring step per cycle: the divide brings in one bit, the root two.
  always_comb begin
    if (op_q == cwts_pkg::OP_DIV) begin
      rem_sh = {rem_q[64:0], wrk_q[63]};
      trial  = {2'b00, den_q};
    end else begin
      rem_sh = {rem_q[63:0], wrk_q[63:62]};
      trial  = {res_q, 2'b01};
    end
    fits = (rem_sh >= trial);
  end

  always_comb begin
    rem_d  = rem_q;
    wrk_d  = wrk_q;
    res_d  = res_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    op_d   = op_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      res_d = '0;
      wrk_d = num_i;
      den_d = den_i;
      op_d  = op_i;
      cnt_d = (op_i == cwts_pkg::OP_DIV) ? 6'd63 : 6'd31;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? (rem_sh - trial) : rem_sh;
      res_d = {res_q[62:0], fits};
      wrk_d = (op_q == cwts_pkg::OP_DIV) ? {wrk_q[62:0], 1'b0} : {wrk_q[61:0], 2'b00};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      wrk_q  <= '0;
      res_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      op_q   <= cwts_pkg::OP_SQRT;
    end else begin
      rem_q  <= rem_d;
      wrk_q  <= wrk_d;
      res_q  <= res_d;
      den_q  <= den_d;
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/charge_weighted_transverse_separation_unit.sv
// Channel   Direction  Handshake            Payload
// config    in         cfg_we_i             cfg_idx_i, cfg_wdata_i
// hit       in         start_i, busy_o      point_x/y/z_i, hit_charge_i, has_point_i, last_hit_i
// result    out        valid_o (strobe)     separation_o, no_charge_o
//
// A hit request is taken when start_i is high, busy_o is low and no
// configuration write is taken. A hit with a space point keeps the block busy;
// the shared square root unit (32 steps) takes most of that time. A last hit
// adds the 64 step divide, or only S_FIN_GO when the total charge or the
// weighted sum is not positive. A skipped hit that is not last never raises
// busy_o. A write to index 0 to 5 recomputes the axis with busy_o high: three
// squares, and one root and three divides unless vertex and start coincide.
// Reset clears the configuration, the axis and both accumulators.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module charge_weighted_transverse_separation_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cwts_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [cwts_pkg::PosW-1:0]          cfg_wdata_i,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [cwts_pkg::PosW-1:0]   point_x_i,
  input  logic signed [cwts_pkg::PosW-1:0]   point_y_i,
  input  logic signed [cwts_pkg::PosW-1:0]   point_z_i,
  input  logic signed [cwts_pkg::ChargeW-1:0] hit_charge_i,
  input  logic                               has_point_i,
  input  logic                               last_hit_i,
  output logic                               valid_o,
  output logic [cwts_pkg::SepW-1:0]          separation_o,
  output logic                               no_charge_o
);

  localparam int unsigned DiffW = cwts_pkg::DiffW;

  // Sequencer states.
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_AX_MUL    = 5'd1;
  localparam logic [4:0] S_AX_ACC    = 5'd2;
  localparam logic [4:0] S_AX_SQ_GO  = 5'd3;
  localparam logic [4:0] S_AX_SQ_W   = 5'd4;
  localparam logic [4:0] S_AX_DV_GO  = 5'd5;
  localparam logic [4:0] S_AX_DV_W   = 5'd6;
  localparam logic [4:0] S_H_M1      = 5'd7;
  localparam logic [4:0] S_H_M2      = 5'd8;
  localparam logic [4:0] S_H_SUB     = 5'd9;
  localparam logic [4:0] S_H_SQ      = 5'd10;
  localparam logic [4:0] S_H_SACC    = 5'd11;
  localparam logic [4:0] S_H_RT_GO   = 5'd12;
  localparam logic [4:0] S_H_RT_W    = 5'd13;
  localparam logic [4:0] S_H_TQ      = 5'd14;
  localparam logic [4:0] S_H_ACC     = 5'd15;
  localparam logic [4:0] S_FIN_GO    = 5'd16;
  localparam logic [4:0] S_FIN_W     = 5'd17;

  logic [4:0] state_q, state_d;
  logic [1:0] idx_q, idx_d;

  logic signed [cwts_pkg::PosW-1:0]    vtx_q [3];
  logic signed [cwts_pkg::PosW-1:0]    sta_q [3];
  logic signed [cwts_pkg::PosW-1:0]    vtx_d [3];
  logic signed [cwts_pkg::PosW-1:0]    sta_d [3];
  logic signed [cwts_pkg::AxisW-1:0]   axis_q [3];
  logic signed [cwts_pkg::AxisW-1:0]   axis_d [3];
  logic signed [cwts_pkg::DiffW-1:0]   p_q [3];
  logic signed [cwts_pkg::DiffW-1:0]   p_d [3];
  logic                                axis_valid_q, axis_valid_d;
  logic signed [cwts_pkg::ChargeW-1:0] chg_q, chg_d;
  logic                                last_q, last_d;
  logic [63:0]                         acc_q, acc_d;
  logic [30:0]                         len_q, len_d;
  logic signed [39:0]                  cr_q, cr_d;
  logic [29:0]                         rv_q, rv_d;
  logic [22:0]                         tv_q, tv_d;
  logic signed [cwts_pkg::TotW-1:0]    tot_q, tot_d;
  logic signed [cwts_pkg::SumW-1:0]    wsum_q, wsum_d;
  logic                                valid_q, valid_d;
  logic [cwts_pkg::SepW-1:0]           sep_q, sep_d;
  logic                                nochg_q, nochg_d;

  // Shared multiplier and root/divide unit.
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod;
  logic                rd_start;
  cwts_pkg::rd_op_e    rd_op;
  logic [63:0]         rd_num, rd_den, rd_res;
  logic                rd_done;

  cwts_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .p_o    (prod)
  );

  cwts_rootdiv u_rootdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rd_start),
    .op_i    (rd_op),
    .num_i   (rd_num),
    .den_i   (rd_den),
    .done_o  (rd_done),
    .res_o   (rd_res)
  );

  // Component indexes that the cross product pairs with component idx.
  function automatic logic [1:0] rot1(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rot2(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] lim(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd0;
      2'd1:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  logic [1:0]                        i0, i1, i2;
  logic signed [cwts_pkg::DiffW-1:0] d_sel, d_neg;
  logic [19:0]                       d_mag;
  logic signed [39:0]                c_val, c_neg, c_abs;
  logic [38:0]                       c_rnd;
  logic [31:0]                       t_rnd;
  logic [17:0]                       q_axis;
  logic signed [40:0]                tot_sum;
  logic signed [64:0]                ws_sum;
  logic                              tot_pos, ws_pos;

  always_comb begin
    i0 = lim(idx_q);
    i1 = rot1(i0);
    i2 = rot2(i0);
    // Axis direction component, start minus vertex.
    d_sel = DiffW'(sta_q[i0]) - DiffW'(vtx_q[i0]);
    d_neg = -d_sel;
    d_mag = d_sel[DiffW-1] ? d_neg[19:0] : d_sel[19:0];
    // Cross product component, rounded to Q8 by magnitude.
    c_val = cr_q - prod[39:0];
    c_neg = -c_val;
    c_abs = c_val[39] ? c_neg : c_val;
    c_rnd = c_abs[38:0] + 39'd128;
    t_rnd = {1'b0, rd_res[30:0]} + 32'd128;
    q_axis = rd_res[17:0];
    tot_sum = {tot_q[39], tot_q} + 41'(chg_q);
    ws_sum  = {wsum_q[63], wsum_q} + {prod[63], prod};
    tot_pos = !tot_q[39] && (tot_q != '0);
    ws_pos  = !wsum_q[63] && (wsum_q != '0);
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_AX_MUL: begin
        mul_a = {12'd0, d_mag};
        mul_b = {12'd0, d_mag};
      end
      S_H_M1: begin
        mul_a = 32'(axis_q[i1]);
        mul_b = 32'(p_q[i2]);
      end
      S_H_M2: begin
        mul_a = 32'(axis_q[i2]);
        mul_b = 32'(p_q[i1]);
      end
      S_H_SQ: begin
        mul_a = {2'd0, rv_q};
        mul_b = {2'd0, rv_q};
      end
      S_H_TQ: begin
        mul_a = {9'd0, tv_q};
        mul_b = 32'(chg_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rd_start = 1'b0;
    rd_op    = cwts_pkg::OP_SQRT;
    rd_num   = acc_q;
    rd_den   = '0;
    case (state_q)
      S_AX_SQ_GO: begin
        rd_start = 1'b1;
        rd_num   = {acc_q[43:0], 20'd0};
      end
      S_AX_DV_GO: begin
        rd_start = 1'b1;
        rd_op    = cwts_pkg::OP_DIV;
        rd_num   = {18'd0, d_mag, 26'd0} + {34'd0, len_q[30:1]};
        rd_den   = {33'd0, len_q};
      end
      S_H_RT_GO: begin
        rd_start = 1'b1;
        rd_num   = acc_q;
      end
      S_FIN_GO: begin
        rd_start = tot_pos && ws_pos;
        rd_op    = cwts_pkg::OP_DIV;
        rd_num   = wsum_q + {25'd0, tot_q[39:1]};
        rd_den   = {24'd0, tot_q};
      end
      default: begin
        rd_start = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    vtx_d        = vtx_q;
    sta_d        = sta_q;
    axis_d       = axis_q;
    p_d          = p_q;
    axis_valid_d = axis_valid_q;
    chg_d        = chg_q;
    last_d       = last_q;
    acc_d        = acc_q;
    len_d        = len_q;
    cr_d         = cr_q;
    rv_d         = rv_q;
    tv_d         = tv_q;
    tot_d        = tot_q;
    wsum_d       = wsum_q;
    valid_d      = 1'b0;
    sep_d        = sep_q;
    nochg_d      = nochg_q;
    case (state_q)
      S_IDLE: begin
        if (cfg_we_i && (cfg_idx_i <= cwts_pkg::REG_START_Z)) begin
          case (cfg_idx_i)
            cwts_pkg::REG_VERTEX_X: vtx_d[0] = cfg_wdata_i;
            cwts_pkg::REG_VERTEX_Y: vtx_d[1] = cfg_wdata_i;
            cwts_pkg::REG_VERTEX_Z: vtx_d[2] = cfg_wdata_i;
            cwts_pkg::REG_START_X:  sta_d[0] = cfg_wdata_i;
            cwts_pkg::REG_START_Y:  sta_d[1] = cfg_wdata_i;
            default:                sta_d[2] = cfg_wdata_i;
          endcase
          acc_d   = '0;
          idx_d   = 2'd0;
          state_d = S_AX_MUL;
        end else if (start_i) begin
          p_d[0] = DiffW'(point_x_i) - DiffW'(vtx_q[0]);
          p_d[1] = DiffW'(point_y_i) - DiffW'(vtx_q[1]);
          p_d[2] = DiffW'(point_z_i) - DiffW'(vtx_q[2]);
          chg_d  = hit_charge_i;
          last_d = last_hit_i;
          acc_d  = '0;
          idx_d  = 2'd0;
          if (has_point_i) begin
            state_d = S_H_M1;
          end else if (last_hit_i) begin
            state_d = S_FIN_GO;
          end
        end
      end
      S_AX_MUL: begin
        state_d = S_AX_ACC;
      end
      S_AX_ACC: begin
        acc_d = acc_q + prod;
        if (idx_q == 2'd2) begin
          if (acc_d == '0) begin
            // Vertex and start coincide: no axis.
            axis_d[0]    = '0;
            axis_d[1]    = '0;
            axis_d[2]    = '0;
            axis_valid_d = 1'b0;
            state_d      = S_IDLE;
          end else begin
            state_d = S_AX_SQ_GO;
          end
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_AX_MUL;
        end
      end
      S_AX_SQ_GO: begin
        state_d = S_AX_SQ_W;
      end
      S_AX_SQ_W: begin
        if (rd_done) begin
          len_d   = rd_res[30:0];
          idx_d   = 2'd0;
          state_d = S_AX_DV_GO;
        end
      end
      S_AX_DV_GO: begin
        state_d = S_AX_DV_W;
      end
      S_AX_DV_W: begin
        if (rd_done) begin
          axis_d[i0] = d_sel[DiffW-1] ? -$signed(q_axis) : $signed(q_axis);
          if (idx_q == 2'd2) begin
            axis_valid_d = 1'b1;
            state_d      = S_IDLE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = S_AX_DV_GO;
          end
        end
      end
      S_H_M1: begin
        state_d = S_H_M2;
      end
      S_H_M2: begin
        cr_d    = prod[39:0];
        state_d = S_H_SUB;
      end
      S_H_SUB: begin
        rv_d    = c_rnd[37:8];
        state_d = S_H_SQ;
      end
      S_H_SQ: begin
        state_d = S_H_SACC;
      end
      S_H_SACC: begin
        acc_d = acc_q + prod;
        if (idx_q == 2'd2) begin
          state_d = S_H_RT_GO;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = S_H_M1;
        end
      end
      S_H_RT_GO: begin
        state_d = S_H_RT_W;
      end
      S_H_RT_W: begin
        if (rd_done) begin
          tv_d    = axis_valid_q ? t_rnd[30:8] : '0;
          state_d = S_H_TQ;
        end
      end
      S_H_TQ: begin
        state_d = S_H_ACC;
      end
      S_H_ACC: begin
        // Both accumulators saturate at their signed limits.
        if (tot_sum[40] != tot_sum[39]) begin
          tot_d = tot_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end else begin
          tot_d = tot_sum[39:0];
        end
        if (ws_sum[64] != ws_sum[63]) begin
          wsum_d = ws_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          wsum_d = ws_sum[63:0];
        end
        state_d = last_q ? S_FIN_GO : S_IDLE;
      end
      S_FIN_GO: begin
        if (tot_pos && ws_pos) begin
          state_d = S_FIN_W;
        end else begin
          valid_d = 1'b1;
          sep_d   = '0;
          nochg_d = !tot_pos;
          tot_d   = '0;
          wsum_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_FIN_W: begin
        if (rd_done) begin
          valid_d = 1'b1;
          sep_d   = (rd_res > 64'(cwts_pkg::SEP_MAX)) ? cwts_pkg::SEP_MAX : rd_res[20:0];
          nochg_d = 1'b0;
          tot_d   = '0;
          wsum_d  = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      vtx_q        <= '{default: '0};
      sta_q        <= '{default: '0};
      axis_q       <= '{default: '0};
      p_q          <= '{default: '0};
      axis_valid_q <= 1'b0;
      chg_q        <= '0;
      last_q       <= 1'b0;
      acc_q        <= '0;
      len_q        <= '0;
      cr_q         <= '0;
      rv_q         <= '0;
      tv_q         <= '0;
      tot_q        <= '0;
      wsum_q       <= '0;
      valid_q      <= 1'b0;
      sep_q        <= '0;
      nochg_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      vtx_q        <= vtx_d;
      sta_q        <= sta_d;
      axis_q       <= axis_d;
      p_q          <= p_d;
      axis_valid_q <= axis_valid_d;
      chg_q        <= chg_d;
      last_q       <= last_d;
      acc_q        <= acc_d;
      len_q        <= len_d;
      cr_q         <= cr_d;
      rv_q         <= rv_d;
      tv_q         <= tv_d;
      tot_q        <= tot_d;
      wsum_q       <= wsum_d;
      valid_q      <= valid_d;
      sep_q        <= sep_d;
      nochg_q      <= nochg_d;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign valid_o      = valid_q;
  assign separation_o = sep_q;
  assign no_charge_o  = nochg_q;

`ifndef NO_ASSERTIONS
  // A result only follows work on a last hit.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o)) else $error("result strobe without preceding work");

  // A forced zero result carries no separation.
  a_nocharge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && no_charge_o) |-> (separation_o == '0)) else $error("no_charge with nonzero value");

  // The root/divide unit only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_done |-> (state_q == S_AX_SQ_W || state_q == S_AX_DV_W ||
                 state_q == S_H_RT_W || state_q == S_FIN_W)) else $error("stray unit done");

  // An invalid axis at rest is the zero vector.
  a_axis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !axis_valid_q) |->
      (axis_q[0] == '0 && axis_q[1] == '0 && axis_q[2] == '0)) else $error("stale axis");

  // Accumulators are empty after every result.
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (tot_q == '0 && wsum_q == '0)) else $error("accumulators not cleared");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [cwts_pkg::SepW-1:0] sep;
    logic                      empty_total;
  } sep_result_t;

  // Keeps its own copy of the geometry and the accumulators, and queues
  // the separation that each closing hit must produce.
  class separation_board;
    longint      vtx[3];
    longint      shw[3];
    longint      axis[3];
    bit          axis_ok;
    longint      charge_sum;
    longint      weighted;
    sep_result_t pending[$];
    int          errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        vtx[i] = 0;
        shw[i] = 0;
        axis[i] = 0;
      end
      axis_ok = 0;
      charge_sum = 0;
      weighted = 0;
      errors = 0;
    endfunction

    function longint unsigned magn(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Integer square root, one result bit per step from the top.
    function longint unsigned root(longint unsigned x);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= x) r = trial;
      end
      return r;
    endfunction

    function void rebuild_axis();
      longint d[3];
      longint unsigned l2;
      longint unsigned len;
      longint unsigned q;
      l2 = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = shw[i] - vtx[i];
        l2 += magn(d[i]) * magn(d[i]);
      end
      if (l2 == 0) begin
        for (int i = 0; i < 3; i++) axis[i] = 0;
        axis_ok = 0;
        return;
      end
      len = root(l2 << 20);
      for (int i = 0; i < 3; i++) begin
        q = ((magn(d[i]) << 26) + len / 2) / len;
        axis[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
      end
      axis_ok = 1;
    endfunction

    function void write_reg(logic [cwts_pkg::CfgIdxW-1:0] idx,
                            logic [cwts_pkg::PosW-1:0] data);
      longint v;
      v = longint'($signed(data));
      case (idx)
        cwts_pkg::REG_VERTEX_X: vtx[0] = v;
        cwts_pkg::REG_VERTEX_Y: vtx[1] = v;
        cwts_pkg::REG_VERTEX_Z: vtx[2] = v;
        cwts_pkg::REG_START_X:  shw[0] = v;
        cwts_pkg::REG_START_Y:  shw[1] = v;
        cwts_pkg::REG_START_Z:  shw[2] = v;
        default: return;
      endcase
      rebuild_axis();
    endfunction

    function longint clamp_add(longint a, longint b, longint lo, longint hi);
      if (b > 0 && a > hi - b) return hi;
      if (b < 0 && a < lo - b) return lo;
      return a + b;
    endfunction

    // Called for every accepted hit request.
    function void note_hit(logic signed [cwts_pkg::PosW-1:0] px,
                           logic signed [cwts_pkg::PosW-1:0] py,
                           logic signed [cwts_pkg::PosW-1:0] pz,
                           logic signed [cwts_pkg::ChargeW-1:0] q,
                           bit hp, bit lst);
      longint p[3];
      longint c[3];
      longint qq;
      longint unsigned s;
      longint unsigned r;
      longint unsigned t;
      longint unsigned res;
      longint unsigned tot;
      sep_result_t e;
      if (hp) begin
        p[0] = longint'(px) - vtx[0];
        p[1] = longint'(py) - vtx[1];
        p[2] = longint'(pz) - vtx[2];
        qq = longint'(q);
        c[0] = axis[1] * p[2] - axis[2] * p[1];
        c[1] = axis[2] * p[0] - axis[0] * p[2];
        c[2] = axis[0] * p[1] - axis[1] * p[0];
        s = 0;
        for (int i = 0; i < 3; i++) begin
          r = (magn(c[i]) + 128) >> 8;
          s += r * r;
        end
        t = axis_ok ? ((root(s) + 128) >> 8) : 0;
        charge_sum = clamp_add(charge_sum, qq, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
        weighted = clamp_add(weighted, longint'(t) * qq,
                             64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF);
      end
      if (!lst) return;
      if (charge_sum <= 0) begin
        e.sep = '0;
        e.empty_total = 1'b1;
      end else begin
        res = 0;
        if (weighted > 0) begin
          tot = charge_sum;
          res = (longint'(unsigned'(weighted)) + tot / 2) / tot;
          res = (64'(unsigned'(weighted)) + tot / 2) / tot;
          if (res > 64'(cwts_pkg::SEP_MAX)) res = 64'(cwts_pkg::SEP_MAX);
        end
        e.sep = res[cwts_pkg::SepW-1:0];
        e.empty_total = 1'b0;
      end
      pending = {pending, e};
      charge_sum = 0;
      weighted = 0;
    endfunction

    task report_mismatch(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [cwts_pkg::SepW-1:0] sep, logic nc);
      sep_result_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result sep=%0d no_charge=%0b", sep, nc));
        return;
      end
      e = pending.pop_front();
      if (sep !== e.sep)
        report_mismatch($sformatf("separation %0d, predicted %0d", sep, e.sep));
      if (nc !== e.empty_total)
        report_mismatch($sformatf("no_charge %0b, predicted %0b", nc, e.empty_total));
    endtask
  endclass

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i = 1'b0;
  logic [cwts_pkg::CfgIdxW-1:0]         cfg_idx_i = '0;
  logic [cwts_pkg::PosW-1:0]            cfg_wdata_i = '0;
  logic                                 start_i = 1'b0;
  logic                                 busy_o;
  logic signed [cwts_pkg::PosW-1:0]     point_x_i = '0;
  logic signed [cwts_pkg::PosW-1:0]     point_y_i = '0;
  logic signed [cwts_pkg::PosW-1:0]     point_z_i = '0;
  logic signed [cwts_pkg::ChargeW-1:0]  hit_charge_i = '0;
  logic                                 has_point_i = 1'b0;
  logic                                 last_hit_i = 1'b0;
  logic                                 valid_o;
  logic [cwts_pkg::SepW-1:0]            separation_o;
  logic                                 no_charge_o;

  separation_board board = new();
  bit                no_gaps;

  localparam logic signed [cwts_pkg::PosW-1:0]    PMAX = 20'sh7FFFF;
  localparam logic signed [cwts_pkg::PosW-1:0]    PMIN = 20'sh80000;
  localparam logic signed [cwts_pkg::ChargeW-1:0] QMAX = 24'sh7FFFFF;
  localparam logic signed [cwts_pkg::ChargeW-1:0] QMIN = 24'sh800000;

  always #5 clk_i = ~clk_i;

  charge_weighted_transverse_separation_unit dut (.*);

  // Results cannot be held off, so every strobe is checked at the edge that
  // ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) board.check_result(separation_o, no_charge_o);
  end

  // Sends one hit request. Start stays high from one request to the next
  // when no gap is drawn, so it is never lowered and raised in one step.
  task automatic send_hit(input logic signed [cwts_pkg::PosW-1:0] x,
                          input logic signed [cwts_pkg::PosW-1:0] y,
                          input logic signed [cwts_pkg::PosW-1:0] z,
                          input logic signed [cwts_pkg::ChargeW-1:0] q,
                          input bit hp, input bit lst);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    hit_charge_i <= q;
    has_point_i <= hp;
    last_hit_i <= lst;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    board.note_hit(x, y, z, q, hp, lst);
  endtask

  // Waits for every predicted result, then lets a hit still in flight
  // finish before the block is touched again.
  task automatic drain();
    start_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cwts_pkg::CfgIdxW-1:0] idx,
                           input logic [cwts_pkg::PosW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    // The axis is recomputed after a write to a geometry register; wait until it is done.
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [cwts_pkg::PosW-1:0] vx,
                              input logic [cwts_pkg::PosW-1:0] vy,
                              input logic [cwts_pkg::PosW-1:0] vz,
                              input logic [cwts_pkg::PosW-1:0] sx,
                              input logic [cwts_pkg::PosW-1:0] sy,
                              input logic [cwts_pkg::PosW-1:0] sz);
    write_reg(cwts_pkg::REG_VERTEX_X, vx);
    write_reg(cwts_pkg::REG_VERTEX_Y, vy);
    write_reg(cwts_pkg::REG_VERTEX_Z, vz);
    write_reg(cwts_pkg::REG_START_X, sx);
    write_reg(cwts_pkg::REG_START_Y, sy);
    write_reg(cwts_pkg::REG_START_Z, sz);
  endtask

  function automatic logic [cwts_pkg::PosW-1:0] rand_reg();
    logic [31:0] raw;
    raw = $urandom;
    return raw[cwts_pkg::PosW-1:0];
  endfunction

  function automatic logic signed [cwts_pkg::PosW-1:0] rand_pos(longint center);
    logic [31:0] raw;
    longint      near;
    raw = $urandom;
    near = center + longint'($urandom_range(0, 8000)) - 4000;
    case ($urandom_range(0, 5))
      0: return raw[cwts_pkg::PosW-1:0];
      1: return $urandom_range(0, 1) ? PMAX : PMIN;
      default: return near[cwts_pkg::PosW-1:0];
    endcase
  endfunction

  function automatic logic signed [cwts_pkg::ChargeW-1:0] rand_charge();
    logic [31:0] raw;
    logic [31:0] neg;
    logic [31:0] pos;
    raw = $urandom;
    neg = -$urandom_range(0, 50000);
    pos = $urandom_range(1, 200000);
    case ($urandom_range(0, 9))
      0: return raw[cwts_pkg::ChargeW-1:0];
      1: return neg[cwts_pkg::ChargeW-1:0];
      2: return $urandom_range(0, 1) ? QMAX : QMIN;
      default: return pos[cwts_pkg::ChargeW-1:0];
    endcase
  endfunction

  // One shower of random length; most are well formed, a few have random flags.
  task automatic random_shower(inout int sent);
    int  len;
    bit  noisy;
    bit  hp;
    bit  lst;
    len = $urandom_range(1, 7);
    noisy = ($urandom_range(0, 9) == 0);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      hp = noisy ? $urandom_range(0, 1) : ($urandom_range(0, 9) != 0);
      lst = noisy ? ($urandom_range(0, 2) == 0 || i == len - 1) : (i == len - 1);
      send_hit(rand_pos(board.shw[0]), rand_pos(board.shw[1]), rand_pos(board.shw[2]),
               rand_charge(), hp, lst);
      sent++;
    end
    if ($urandom_range(0, 19) == 0) drain();
  endtask

  initial begin
    int sent;
    no_gaps = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the axis is zero: charge counts, distance does not.
    send_hit(PMAX, PMIN, PMAX, QMAX, 1, 0);
    send_hit(PMIN, PMAX, PMIN, 24'sd5, 1, 1);
    send_hit(20'sd3, 20'sd4, 20'sd5, QMIN, 1, 1);
    send_hit(20'sd0, 20'sd0, 20'sd0, 24'sd0, 1, 1);
    send_hit(PMAX, PMAX, PMAX, QMAX, 0, 1);
    send_hit(20'sd1, 20'sd1, 20'sd1, 24'sd100, 1, 0);
    send_hit(PMIN, PMIN, PMIN, QMAX, 0, 1);
    drain();

    // Ignored register indexes must leave the geometry alone.
    write_reg(3'd6, 20'hFFFFF);
    write_reg(3'd7, 20'h55555);

    // Extreme geometry: the axis runs along x over the full range.
    set_geometry(PMAX, PMAX, PMAX, PMIN, PMAX, PMAX);
    send_hit(PMIN, PMIN, PMIN, QMAX, 1, 1);
    // Opposite full-scale charges cancel to a zero total and a no_charge result.
    send_hit(PMIN, PMIN, PMIN, QMAX, 1, 0);
    send_hit(PMAX, PMAX, PMAX, 24'sh800001, 1, 1);
    // A negative weighted sum with a positive total gives zero.
    send_hit(PMAX, PMIN, PMIN, -24'sd1000, 1, 0);
    send_hit(PMAX, PMAX, PMAX, 24'sd2000, 1, 1);
    // Total exactly zero, then negative.
    send_hit(PMAX, 20'sd0, 20'sd0, 24'sd77, 1, 0);
    send_hit(PMAX, 20'sd9, 20'sd0, -24'sd77, 1, 1);
    send_hit(PMIN, 20'sd0, PMIN, -24'sd1, 1, 1);
    // A skipped closing hit still closes the shower.
    send_hit(20'sd5, 20'sd123, 20'sd456, 24'sd1000, 1, 0);
    send_hit(PMIN, PMIN, PMIN, QMIN, 0, 1);
    send_hit(PMAX, PMAX, PMAX, QMAX, 1, 1);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_geometry(20'd0, 20'd0, 20'd0, 20'd640, 20'd640, 20'd640);
        1: set_geometry(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX);
        // Coincident vertex and start.
        2: set_geometry(20'h12345, 20'hABCDE, 20'h00001, 20'h12345, 20'hABCDE, 20'h00001);
        3: set_geometry(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd1);
        default: set_geometry(rand_reg(), rand_reg(), rand_reg(),
                              rand_reg(), rand_reg(), rand_reg());
      endcase
      sent = 0;
      while (sent < 105) random_shower(sent);
      drain();
    end

    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/cwts_pkg.sv
rtl/cwts_mul.sv
rtl/cwts_rootdiv.sv
rtl/charge_weighted_transverse_separation_unit.sv
sim/testbench.sv
